// ===== design/unique_value_set_table_unit_macros.svh =====
// Assertion macros for the set table RTL.
`ifndef UNIQUE_VALUE_SET_TABLE_UNIT_MACROS_SVH
`define UNIQUE_VALUE_SET_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define UVST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvst: same-cycle check failed");

`define UVST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvst: next-cycle check failed");

`else

`define UVST_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define UVST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/uvst_pkg.sv =====
// Package with sizes, codes and cell control types for the set table.
package uvst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 36;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_PRESENT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL        = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_DECIDE
    } state_t;

    // Signals sent to every cell alike.
    typedef struct packed {
        logic             cmp_en;
        logic [VAL_W-1:0] key;
    } cell_bcast_t;

    // Per-cell load selects.
    typedef struct packed {
        logic load_key;
        logic load_next;
    } cell_sel_t;

endpackage

// ===== design/uvst_cell.sv =====
// One table cell: holds an entry, compares it with the key, shifts from its neighbor.
module uvst_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  uvst_pkg::cell_bcast_t     bcast,
    input  uvst_pkg::cell_sel_t       sel,
    input  logic                      occupied,
    input  logic [uvst_pkg::VAL_W-1:0] next_entry,
    output logic [uvst_pkg::VAL_W-1:0] entry,
    output logic                      hit
);
    import uvst_pkg::*;

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic             hit_reg;
    logic             hit_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (sel.load_key)
        begin
            entry_next = bcast.key;
        end
        else if (sel.load_next)
        begin
            entry_next = next_entry;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (bcast.cmp_en)
        begin
            hit_next = occupied && (entry_reg == bcast.key);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// ===== design/unique_value_set_table_unit.sv =====
// Top level of the set table: control sequencer, row of cells, count and total.
//
// The block keeps up to sixteen distinct signed Q16.16 values in insertion
// order together with their 36-bit sum. An input item (action, item_value) is
// taken when in_valid is high and in_stall is low; action 0 finds, 1 adds the
// value if absent, 2 removes it if present, and 3 acts as a find.
// Every item gives exactly one result item on the output channel: status,
// position, entry_count and total, taken when out_valid is high and out_stall
// is low.
// An item passes a compare step, where every cell compares its entry with the key,
// and an update step, where the single hit is encoded and the table is updated;
// a remove moves all later entries down one cell in that same step. The result is
// registered, and the next item can be taken once the block is back in idle.
// The result sits in an output register; a stalled receiver holds the block in
// its update step until that register is free, and in_stall stays high.
// Reset empties the table and clears the total at once.
`include "unique_value_set_table_unit_macros.svh"

module unique_value_set_table_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [uvst_pkg::ACT_W-1:0]         action,
    input  logic signed [uvst_pkg::VAL_W-1:0]  item_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [uvst_pkg::STAT_W-1:0]        status,
    output logic [uvst_pkg::IDX_W-1:0]         position,
    output logic [uvst_pkg::CNT_W-1:0]         entry_count,
    output logic signed [uvst_pkg::SUM_W-1:0]  total
);
    import uvst_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [ACT_W-1:0]  action_reg;
    logic [VAL_W-1:0]  key_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [IDX_W-1:0]  position_reg;
    logic [IDX_W-1:0]  position_next;

    logic              accept;
    logic              cmp_en;
    logic              commit;
    logic              add_ok;
    logic              rem_ok;
    logic              found;
    logic [IDX_W-1:0]  hit_pos;
    logic [SUM_W-1:0]  key_wide;

    cell_bcast_t       bcast;
    cell_sel_t         sel [CAPACITY];
    logic [VAL_W-1:0]  entry [CAPACITY];
    logic [VAL_W-1:0]  nbr_entry [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] occupied;

    assign accept = in_valid && !in_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_stall = 1'b1;
        cmp_en   = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_COMPARE:
            begin
                cmp_en = 1'b1;
            end
            ST_DECIDE:
            begin
                commit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign bcast.cmp_en = cmp_en;
    assign bcast.key    = key_reg;

    // Values in the table are distinct, so at most one cell hits.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit_vec[i])
            begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    assign found    = |hit_vec;
    assign key_wide = {{(SUM_W - VAL_W){key_reg[VAL_W-1]}}, key_reg};

    // Result and update of count and total.
    always_comb
    begin
        add_ok        = 1'b0;
        rem_ok        = 1'b0;
        status_next   = STAT_OK;
        position_next = '0;
        case (action_reg)
            ACT_ADD:
            begin
                if (found)
                begin
                    status_next   = STAT_DUPLICATE;
                    position_next = hit_pos;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    add_ok        = 1'b1;
                    position_next = count_reg[IDX_W-1:0];
                end
            end
            ACT_REMOVE:
            begin
                if (found)
                begin
                    rem_ok        = 1'b1;
                    position_next = hit_pos;
                end
                else
                begin
                    status_next = STAT_NOT_PRESENT;
                end
            end
            default:
            begin
                if (found)
                begin
                    position_next = hit_pos;
                end
                else
                begin
                    status_next = STAT_NOT_PRESENT;
                end
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (commit && add_ok)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + key_wide;
        end
        else if (commit && rem_ok)
        begin
            count_next = count_reg - 1'b1;
            sum_next   = sum_reg - key_wide;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign occupied[i]      = CNT_W'(i) < count_reg;
        assign sel[i].load_key  = commit && add_ok && (count_reg == CNT_W'(i));
        assign sel[i].load_next = commit && rem_ok && (IDX_W'(i) >= hit_pos);

        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr_entry[i] = entry[i];
        end
        else
        begin : g_inner
            assign nbr_entry[i] = entry[i+1];
        end

        uvst_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .bcast      (bcast),
            .sel        (sel[i]),
            .occupied   (occupied[i]),
            .next_entry (nbr_entry[i]),
            .entry      (entry[i]),
            .hit        (hit_vec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            key_reg    <= item_value;
        end
        if (commit)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = count_reg;
    assign total       = $signed(sum_reg);

    `UVST_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `UVST_ASSERT_IMPLIES(a_single_hit, clk, rst_n, state_reg == ST_DECIDE, $onehot0(hit_vec))
    `UVST_ASSERT_NEXT(a_accept_compare, clk, rst_n, accept, state_reg == ST_COMPARE)
    `UVST_ASSERT_NEXT(a_result_drain, clk, rst_n, out_valid && !out_stall && !commit, !out_valid)
    `UVST_ASSERT_NEXT(a_remove_count, clk, rst_n, commit && rem_ok, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== dv/tb_unique_value_set_table_unit.sv =====
// Self-checking testbench for the set table: random set operations scored against a table model.
module tb_unique_value_set_table_unit;
    import uvst_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT_RESULT = 600;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int POOL_SIZE = 20;

    typedef enum int {
        POOL_WIDE,
        POOL_HIGH,
        POOL_LOW,
        POOL_NEAR_ZERO,
        POOL_MIXED
    } pool_style_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        logic             quiet;
    } set_op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  position;
        logic [CNT_W-1:0]  entry_count;
        logic [SUM_W-1:0]  total;
    } set_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [ACT_W-1:0]         action = '0;
    logic signed [VAL_W-1:0]  item_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STAT_W-1:0]        status;
    logic [IDX_W-1:0]         position;
    logic [CNT_W-1:0]         entry_count;
    logic signed [SUM_W-1:0]  total;

    // Table contents as the block should hold them after every accepted item.
    logic [VAL_W-1:0]         shadow_vals[CAPACITY];
    int                       shadow_count = 0;
    logic [SUM_W-1:0]         shadow_sum = '0;

    // Membership as seen by the stimulus generator, ahead of the block.
    logic [VAL_W-1:0]         gen_members[$];

    set_op_t                  op_backlog[$];
    set_result_t              pending_outcomes[$];

    bit                       quiet_tail = 1'b0;
    int                       gap_left = 0;
    int                       stall_left = 0;
    int                       hold_left = 0;
    bit                       hold_done = 1'b0;
    int                       cycle_count = 0;
    int                       results_seen = 0;
    int                       mismatches = 0;
    int                       op_tally[4] = '{default: 0};
    int                       status_tally[4] = '{default: 0};

    unique_value_set_table_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .position    (position),
        .entry_count (entry_count),
        .total       (total)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding",
                     pending_outcomes.size());
            $display("** unique_value_set_table_unit: FAILED **");
            $finish;
        end
    end

    // Applies one operation to the shadow table and returns what the block must report.
    function automatic set_result_t apply_set_op(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val);
        set_result_t r;
        int hit;
        r = '0;
        hit = -1;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_vals[i] == val)
                hit = i;
        end
        r.status = STAT_OK;
        case (act)
            ACT_ADD:
            begin
                if (hit >= 0)
                begin
                    r.status = STAT_DUPLICATE;
                    r.position = IDX_W'(hit);
                end
                else if (shadow_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    r.position = IDX_W'(shadow_count);
                    shadow_vals[shadow_count] = val;
                    shadow_count++;
                    shadow_sum = shadow_sum + {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
                end
            end
            ACT_REMOVE:
            begin
                if (hit < 0)
                    r.status = STAT_NOT_PRESENT;
                else
                begin
                    r.position = IDX_W'(hit);
                    for (int i = hit; i < shadow_count - 1; i++)
                        shadow_vals[i] = shadow_vals[i + 1];
                    shadow_count--;
                    shadow_sum = shadow_sum - {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
                end
            end
            default:
            begin
                // The spare action code behaves exactly like a find.
                if (hit < 0)
                    r.status = STAT_NOT_PRESENT;
                else
                    r.position = IDX_W'(hit);
            end
        endcase
        r.entry_count = CNT_W'(shadow_count);
        r.total = shadow_sum;
        return r;
    endfunction

    function automatic int member_index(logic [VAL_W-1:0] v);
        int idx;
        idx = -1;
        foreach (gen_members[i])
        begin
            if (idx < 0 && gen_members[i] == v)
                idx = i;
        end
        return idx;
    endfunction

    task automatic push_op(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                           input bit quiet);
        set_op_t op;
        int at;
        at = member_index(val);
        op.act = act;
        op.val = val;
        op.quiet = quiet;
        op_backlog.push_back(op);
        if (act == ACT_ADD && at < 0 && gen_members.size() < CAPACITY)
            gen_members.push_back(val);
        else if (act == ACT_REMOVE && at >= 0)
            gen_members.delete(at);
    endtask

    // One phase draws from a small value pool so that hits, duplicates and a full table
    // are common; finds and removes mostly aim at values that are stored.
    task automatic queue_random_phase(input int n, input bit quiet);
        logic [VAL_W-1:0] pool[POOL_SIZE];
        pool_style_t style;
        int add_pct;
        int rem_pct;
        int roll;
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        style = pool_style_t'($urandom_range(0, 4));
        add_pct = $urandom_range(20, 60);
        rem_pct = $urandom_range(15, 35);
        foreach (pool[i])
        begin
            case (style)
                POOL_WIDE:      pool[i] = $urandom;
                POOL_HIGH:      pool[i] = 32'h7000_0000 | ($urandom & 32'h0FFF_FFFF);
                POOL_LOW:       pool[i] = 32'h8000_0000 | ($urandom & 32'h0FFF_FFFF);
                POOL_NEAR_ZERO: pool[i] = $urandom_range(0, 16) - 8;
                default:        pool[i] = (i % 2) ? $urandom : ($urandom_range(0, 6) - 3);
            endcase
        end
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                act = ACT_ADD;
            else if (roll < add_pct + rem_pct)
                act = ACT_REMOVE;
            else if (roll < 95)
                act = ACT_FIND;
            else
                act = ACT_SPARE;
            if (act != ACT_ADD && gen_members.size() != 0 && $urandom_range(0, 99) < 65)
                val = gen_members[$urandom_range(0, gen_members.size() - 1)];
            else if ($urandom_range(0, 9) == 0)
                val = $urandom;
            else
                val = pool[$urandom_range(0, POOL_SIZE - 1)];
            push_op(act, val, quiet);
        end
    endtask

    // Sender side: an item stays on the port, unchanged, until it is taken.
    always @(posedge clk)
    begin
        set_op_t op;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pending_outcomes.push_back(apply_set_op(action, item_value));
                op_tally[action]++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (op_backlog.size() != 0 && !op_backlog[0].quiet
                         && $urandom_range(0, 99) < 10)
                begin
                    gap_left = $urandom_range(1, 14) - 1;
                    in_valid <= 1'b0;
                end
                else if (op_backlog.size() != 0)
                begin
                    op = op_backlog.pop_front();
                    if (op.quiet)
                        quiet_tail = 1'b1;
                    action <= op.act;
                    item_value <= op.val;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver side: scores each result and throttles the output with random stalls.
    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result with nothing outstanding: status %0d pos %0d count %0d total %0h",
                                 status, position, entry_count, total);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    status_tally[want.status]++;
                    if (status !== want.status || position !== want.position
                        || entry_count !== want.entry_count || total !== want.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result %0d differs: expected status %0d pos %0d count %0d total %0h, got status %0d pos %0d count %0d total %0h",
                                     results_seen, want.status, want.position, want.entry_count,
                                     want.total, status, position, entry_count, total);
                    end
                end
            end
            // One long hold-off mid-run, so the block backs up and stalls its input.
            if (!hold_done && results_seen == HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < 12)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty-table misses, the value extremes, a duplicate, the spare code,
        // a remove at the head, a fill to capacity, full and duplicate-on-full,
        // and a remove of the last entry.
        push_op(ACT_FIND, 32'h0000_0000, 1'b0);
        push_op(ACT_REMOVE, 32'h0000_1234, 1'b0);
        push_op(ACT_ADD, 32'h8000_0000, 1'b0);
        push_op(ACT_ADD, 32'h7FFF_FFFF, 1'b0);
        push_op(ACT_ADD, 32'hFFFF_FFFF, 1'b0);
        push_op(ACT_ADD, 32'h7FFF_FFFF, 1'b0);
        push_op(ACT_SPARE, 32'hFFFF_FFFF, 1'b0);
        push_op(ACT_REMOVE, 32'h8000_0000, 1'b0);
        for (int i = 0; i < CAPACITY - 2; i++)
            push_op(ACT_ADD, 32'h7FFF_0000 + i, 1'b0);
        push_op(ACT_ADD, 32'h0000_0001, 1'b0);
        push_op(ACT_ADD, 32'hFFFF_FFFF, 1'b0);
        push_op(ACT_REMOVE, 32'h7FFF_0000 + CAPACITY - 3, 1'b0);

        // The sender waits here until every result so far has come back.
        while (op_backlog.size() != 0 || in_valid || pending_outcomes.size() != 0)
            @(posedge clk);

        repeat (11)
            queue_random_phase(160, 1'b0);
        while (op_backlog.size() != 0 || in_valid || pending_outcomes.size() != 0)
            @(posedge clk);

        queue_random_phase(120, 1'b1);
        while (op_backlog.size() != 0 || in_valid || pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Applied %0d finds, %0d adds, %0d removes and %0d spare-code finds; %0d results scored",
                 op_tally[ACT_FIND], op_tally[ACT_ADD], op_tally[ACT_REMOVE],
                 op_tally[ACT_SPARE], results_seen);
        $display("Outcomes: %0d ok, %0d duplicate, %0d absent, %0d full; %0d mismatches",
                 status_tally[STAT_OK], status_tally[STAT_DUPLICATE],
                 status_tally[STAT_NOT_PRESENT], status_tally[STAT_FULL], mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("** unique_value_set_table_unit: PASSED **");
        else
            $display("** unique_value_set_table_unit: FAILED **");
        $finish;
    end
endmodule
